// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the normalisation cube map RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every clock edge outside reset
`define NCM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define NCM_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// implication checked in the following cycle
`define NCM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/ncm_pkg.sv =====
// Shared types and constants of the normalisation cube map pipeline
package ncm_pkg;

    localparam int IDX_W  = 10;  // texel index
    localparam int FS_W   = 11;  // face size register
    localparam int Q_W    = 18;  // Q2.16 coordinate
    localparam int T_W    = 17;  // quotient idx*2^17/size
    localparam int SQ_W   = 33;  // square of a coordinate
    localparam int LEN_W  = 34;  // squared length, 32 fraction bits
    localparam int QR_W   = 37;  // floor(2^68 / len2)
    localparam int R_W    = 19;  // reciprocal length, 18 fraction bits
    localparam int P_W    = 38;  // component times reciprocal length
    localparam int TS_W   = 39;  // biased product
    localparam int CH_W   = 8;
    localparam int RGB_W  = 24;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [Q_W-1:0]   coord_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic [QR_W-1:0]         quot_t;
    typedef logic [R_W-1:0]          root_t;
    typedef logic [RGB_W-1:0]        rgb_t;

    localparam coord_t ONE_Q16 = 18'sd65536;

    // register index, taken from paddr[2]
    localparam logic REG_FACE_SIZE = 1'b0;

    // pipeline control handed to each stage module
    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

// ===== rtl/normalization_cube_map_texel_top.sv =====
// Normalisation cube map texel generator. Each accepted word (column, row)
// gives one result word holding the texel of all six cube faces, packed
// as 8-bit r,g,b. The block is a fixed pipeline of 82 register stages:
// 19 for the coordinate dividers (one quotient bit a stage), 2 for the
// squared length, 38 for the reciprocal divider, 20 for the square root
// and 3 for scaling and packing. A new word enters every cycle while the
// pipeline is not held, and the whole pipeline holds while a result waits
// to be taken.
// face_size (APB offset 0) should be written only when no word is in flight.
`include "assert_macros.svh"

module normalization_cube_map_texel_top import ncm_pkg::*; #(
    parameter int MAX_FACE_SIZE = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IDX_W-1:0]  s_column,
    input  logic [IDX_W-1:0]  s_row,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [RGB_W-1:0]  m_pos_x_rgb,
    output logic [RGB_W-1:0]  m_neg_x_rgb,
    output logic [RGB_W-1:0]  m_pos_y_rgb,
    output logic [RGB_W-1:0]  m_neg_y_rgb,
    output logic [RGB_W-1:0]  m_pos_z_rgb,
    output logic [RGB_W-1:0]  m_neg_z_rgb,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SW  = $clog2(MAX_FACE_SIZE + 1);
    localparam int CW  = (SW > FS_W) ? SW : FS_W;
    localparam int EW  = (SW > IDX_W) ? SW : IDX_W;
    localparam int TGW = 2 * Q_W;
    localparam len_t  LEN_ONE = LEN_W'(64'h1_0000_0000);
    localparam quot_t QR_ONE  = QR_W'(64'h10_0000_0000);
    localparam root_t R_ONE   = R_W'(32'h4_0000);

    logic [FS_W-1:0]  face_size_reg;
    logic [SW-1:0]    size_eff;
    logic [EW-1:0]    last_idx;
    idx_t             col_c, row_c;
    logic             pipe_en;

    logic             crd_valid;
    coord_t           crd_y, crd_z;
    logic             sq_v_reg, len_v_reg;
    logic [SQ_W-1:0]  ysq_reg, zsq_reg;
    coord_t           sy_reg, sz_reg;
    len_t             len2_reg;
    coord_t           ly_reg, lz_reg;
    logic signed [2*Q_W-1:0] ysq_full, zsq_full;

    logic             rcp_valid;
    quot_t            rcp_q;
    logic [TGW-1:0]   rcp_tag;
    logic             sq_valid;
    root_t            sq_r;
    logic [TGW-1:0]   sq_tag;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_size_reg <= FS_W'(256);
        end else if (psel && penable && pwrite && (paddr[2] == REG_FACE_SIZE)) begin
            face_size_reg <= pwdata[FS_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_FACE_SIZE) ? APB_DW'(face_size_reg) : '0;

    // zero size reads as one, oversized as the maximum; indices past the face clamp to its last
    always_comb begin
        if (face_size_reg == '0) begin
            size_eff = SW'(1);
        end else if (CW'(face_size_reg) > CW'(MAX_FACE_SIZE)) begin
            size_eff = SW'(MAX_FACE_SIZE);
        end else begin
            size_eff = SW'(face_size_reg);
        end
        last_idx = EW'(size_eff) - EW'(1);
        col_c = (EW'(s_column) >= EW'(size_eff)) ? IDX_W'(last_idx) : s_column;
        row_c = (EW'(s_row)    >= EW'(size_eff)) ? IDX_W'(last_idx) : s_row;
    end

    // whole pipeline moves unless a finished word is waiting
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    ncm_coord_div #(.SW(SW)) u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       ('{en: pipe_en, valid: s_valid}),
        .in_size   (size_eff),
        .in_col    (col_c),
        .in_row    (row_c),
        .out_valid (crd_valid),
        .out_y     (crd_y),
        .out_z     (crd_z)
    );

    // squared length: squares, then their sum with one
    assign ysq_full = crd_y * crd_y;
    assign zsq_full = crd_z * crd_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg  <= 1'b0;
            len_v_reg <= 1'b0;
        end else if (pipe_en) begin
            sq_v_reg  <= crd_valid;
            len_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ysq_reg  <= ysq_full[SQ_W-1:0];
            zsq_reg  <= zsq_full[SQ_W-1:0];
            sy_reg   <= crd_y;
            sz_reg   <= crd_z;
            len2_reg <= LEN_ONE + LEN_W'(ysq_reg) + LEN_W'(zsq_reg);
            ly_reg   <= sy_reg;
            lz_reg   <= sz_reg;
        end
    end

    ncm_recip_div #(.TW(TGW)) u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       ('{en: pipe_en, valid: len_v_reg}),
        .in_len    (len2_reg),
        .in_tag    ({ly_reg, lz_reg}),
        .out_valid (rcp_valid),
        .out_q     (rcp_q),
        .out_tag   (rcp_tag)
    );

    ncm_isqrt #(.TW(TGW)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       ('{en: pipe_en, valid: rcp_valid}),
        .in_q      (rcp_q),
        .in_tag    (rcp_tag),
        .out_valid (sq_valid),
        .out_r     (sq_r),
        .out_tag   (sq_tag)
    );

    ncm_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       ('{en: pipe_en, valid: sq_valid}),
        .in_r      (sq_r),
        .in_y      (coord_t'(sq_tag[TGW-1:Q_W])),
        .in_z      (coord_t'(sq_tag[Q_W-1:0])),
        .out_valid (m_valid),
        .out_pos_x (m_pos_x_rgb),
        .out_neg_x (m_neg_x_rgb),
        .out_pos_y (m_pos_y_rgb),
        .out_neg_y (m_neg_y_rgb),
        .out_pos_z (m_pos_z_rgb),
        .out_neg_z (m_neg_z_rgb)
    );

    `NCM_ASSERT(a_size_range, aclk, aresetn, (size_eff != '0) && (CW'(size_eff) <= CW'(MAX_FACE_SIZE)), "effective face size out of range")
    `NCM_ASSERT_IMPL(a_recip_range, aclk, aresetn, rcp_valid, rcp_q <= QR_ONE, "reciprocal quotient above 2^36")
    `NCM_ASSERT_IMPL(a_root_range, aclk, aresetn, sq_valid, sq_r <= R_ONE, "reciprocal length above one")
    `NCM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, $stable(sq_r) && $stable(rcp_q), "pipeline moved during a stall")

endmodule

// ===== rtl/ncm_coord_div.sv =====
// Bit-serial pipelined dividers giving the Q2.16 y and z coordinates
module ncm_coord_div import ncm_pkg::*; #(
    parameter int SW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  stage_ctl_t    ctl,
    input  logic [SW-1:0] in_size,
    input  idx_t          in_col,
    input  idx_t          in_row,
    output logic          out_valid,
    output coord_t        out_y,
    output coord_t        out_z
);

    localparam int NB = T_W;

    logic [NB+1:0]   v_reg;
    logic [SW-1:0]   rr_reg [0:NB];
    logic [SW-1:0]   rc_reg [0:NB];
    logic [NB-1:0]   qr_reg [0:NB];
    logic [NB-1:0]   qc_reg [0:NB];
    coord_t          y_reg;
    coord_t          z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctl.en) begin
            v_reg <= {v_reg[NB:0], ctl.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rr_reg[0] <= SW'(in_row);
            rc_reg[0] <= SW'(in_col);
            qr_reg[0] <= '0;
            qc_reg[0] <= '0;
        end
    end

    // one quotient bit per stage; remainder stays below the face size
    genvar k;
    for (k = 0; k < NB; k++) begin : g_step
        logic [SW:0] tr;
        logic [SW:0] tc;
        logic        ger;
        logic        gec;
        always_comb begin
            tr  = {rr_reg[k], 1'b0};
            tc  = {rc_reg[k], 1'b0};
            ger = tr >= {1'b0, in_size};
            gec = tc >= {1'b0, in_size};
        end
        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                rr_reg[k+1] <= ger ? SW'(tr - {1'b0, in_size}) : SW'(tr);
                rc_reg[k+1] <= gec ? SW'(tc - {1'b0, in_size}) : SW'(tc);
                qr_reg[k+1] <= {qr_reg[k][NB-2:0], ger};
                qc_reg[k+1] <= {qc_reg[k][NB-2:0], gec};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            y_reg <= ONE_Q16 - $signed({1'b0, qr_reg[NB]});
            z_reg <= ONE_Q16 - $signed({1'b0, qc_reg[NB]});
        end
    end

    assign out_valid = v_reg[NB+1];
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ===== rtl/ncm_recip_div.sv =====
// Pipelined restoring divider for floor(2^68 / len2)
module ncm_recip_div import ncm_pkg::*; #(
    parameter int TW = 36
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  stage_ctl_t    ctl,
    input  len_t          in_len,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output quot_t         out_q,
    output logic [TW-1:0] out_tag
);

    localparam int NB = QR_W;
    // 2^68 >> 37, below any len2 since len2 >= 2^32
    localparam len_t REM0 = LEN_W'(64'h8000_0000);

    logic [NB:0]     v_reg;
    len_t            rem_reg [0:NB];
    len_t            d_reg   [0:NB];
    quot_t           q_reg   [0:NB];
    logic [TW-1:0]   tag_reg [0:NB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctl.en) begin
            v_reg <= {v_reg[NB-1:0], ctl.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rem_reg[0] <= REM0;
            d_reg[0]   <= in_len;
            q_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    genvar k;
    for (k = 0; k < NB; k++) begin : g_step
        logic [LEN_W:0] tr;
        logic           ge;
        always_comb begin
            tr = {rem_reg[k], 1'b0};
            ge = tr >= {1'b0, d_reg[k]};
        end
        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                rem_reg[k+1] <= ge ? LEN_W'(tr - {1'b0, d_reg[k]}) : LEN_W'(tr);
                d_reg[k+1]   <= d_reg[k];
                q_reg[k+1]   <= {q_reg[k][NB-2:0], ge};
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NB];
    assign out_q     = q_reg[NB];
    assign out_tag   = tag_reg[NB];

endmodule

// ===== rtl/ncm_isqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage
module ncm_isqrt import ncm_pkg::*; #(
    parameter int TW = 36
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  stage_ctl_t    ctl,
    input  quot_t         in_q,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output root_t         out_r,
    output logic [TW-1:0] out_tag
);

    localparam int NB  = R_W;
    localparam int TWD = QR_W + 3;

    logic [NB:0]     v_reg;
    quot_t           rem_reg [0:NB];
    root_t           res_reg [0:NB];
    logic [TW-1:0]   tag_reg [0:NB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctl.en) begin
            v_reg <= {v_reg[NB-1:0], ctl.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rem_reg[0] <= in_q;
            res_reg[0] <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    // rem holds q - res^2; trying bit i costs res*2^(i+1) + 4^i
    genvar k;
    for (k = 0; k < NB; k++) begin : g_step
        localparam int I = NB - 1 - k;
        logic [TWD-1:0] test;
        logic [TWD-1:0] diff;
        logic           ge;
        always_comb begin
            test = (TWD'(res_reg[k]) << (I + 1)) + (TWD'(1) << (2 * I));
            diff = TWD'(rem_reg[k]) - test;
            ge   = TWD'(rem_reg[k]) >= test;
        end
        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                rem_reg[k+1] <= ge ? QR_W'(diff) : rem_reg[k];
                res_reg[k+1] <= ge ? (res_reg[k] | (R_W'(1) << I)) : res_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NB];
    assign out_r     = res_reg[NB];
    assign out_tag   = tag_reg[NB];

endmodule

// ===== rtl/ncm_shade.sv =====
// Scaling of the unit vector and packing of the six face texels
module ncm_shade import ncm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  stage_ctl_t ctl,
    input  root_t      in_r,
    input  coord_t     in_y,
    input  coord_t     in_z,
    output logic       out_valid,
    output rgb_t       out_pos_x,
    output rgb_t       out_neg_x,
    output rgb_t       out_pos_y,
    output rgb_t       out_neg_y,
    output rgb_t       out_pos_z,
    output rgb_t       out_neg_z
);

    localparam logic signed [TS_W-1:0] HALF = TS_W'(64'sh4_0000_0000);

    logic [2:0]              v_reg;
    logic signed [P_W-1:0]   px_reg, py_reg, pz_reg;
    logic signed [TS_W-1:0]  xp_reg, xm_reg, yp_reg, ym_reg, zp_reg, zm_reg;
    rgb_t                    pxr_reg, nxr_reg, pyr_reg, nyr_reg, pzr_reg, nzr_reg;
    logic signed [R_W:0]     r_s;
    logic signed [P_W-1:0]   py_full, pz_full;
    logic [CH_W-1:0]         cxp, cxm, cyp, cym, czp, czm;

    // floor(t * 255 / 2^35), zero for t <= 0, clamped to 255
    function automatic logic [CH_W-1:0] chan(input logic signed [TS_W-1:0] t);
        logic [TS_W-2:0] tu;
        logic [TS_W+6:0] w;
        logic [11:0]     v;
        begin
            tu = t[TS_W-2:0];
            w  = {tu, 8'b0} - {8'b0, tu};
            v  = {1'b0, w[TS_W+6:35]};
            if (t[TS_W-1] || (t == '0)) begin
                chan = '0;
            end else if (v > 12'd255) begin
                chan = 8'hFF;
            end else begin
                chan = v[CH_W-1:0];
            end
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctl.en) begin
            v_reg <= {v_reg[1:0], ctl.valid};
        end
    end

    assign r_s = $signed({1'b0, in_r});

    // full-width signed products, 34 fraction bits
    assign py_full = in_y * r_s;
    assign pz_full = in_z * r_s;

    always_comb begin
        cxp = chan(xp_reg);
        cxm = chan(xm_reg);
        cyp = chan(yp_reg);
        cym = chan(ym_reg);
        czp = chan(zp_reg);
        czm = chan(zm_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            px_reg  <= P_W'(r_s) <<< 16;
            py_reg  <= py_full;
            pz_reg  <= pz_full;
            xp_reg  <= HALF + TS_W'(px_reg);
            xm_reg  <= HALF - TS_W'(px_reg);
            yp_reg  <= HALF + TS_W'(py_reg);
            ym_reg  <= HALF - TS_W'(py_reg);
            zp_reg  <= HALF + TS_W'(pz_reg);
            zm_reg  <= HALF - TS_W'(pz_reg);
            pxr_reg <= {cxp, cyp, czp};
            nxr_reg <= {cxm, cyp, czm};
            pyr_reg <= {czm, cxp, cym};
            nyr_reg <= {czm, cxm, cyp};
            pzr_reg <= {czm, cyp, cxp};
            nzr_reg <= {czp, cyp, cxm};
        end
    end

    assign out_valid = v_reg[2];
    assign out_pos_x = pxr_reg;
    assign out_neg_x = nxr_reg;
    assign out_pos_y = pyr_reg;
    assign out_neg_y = nyr_reg;
    assign out_pos_z = pzr_reg;
    assign out_neg_z = nzr_reg;

endmodule
